### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the tile map collision block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TMAC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tile map collision check failed");

// Clocked assertion that also holds while reset is asserted.
`define TMAC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tile map collision reset check failed");

`endif

### hw/rtl/tmac_pkg.sv
// Types, constants and helper functions of the tile map collision block.
package tmac_pkg;

    // Item command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_THIRD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_FOURTH = 2'd3;

    localparam int TILE_ID_W = 8;
    localparam logic [TILE_ID_W-1:0] WALL_FIRST_RST  = 8'd1;
    localparam logic [TILE_ID_W-1:0] WALL_SECOND_RST = 8'd2;
    localparam logic [TILE_ID_W-1:0] WALL_THIRD_RST  = 8'd3;
    localparam logic [TILE_ID_W-1:0] WALL_FOURTH_RST = 8'd4;

    // Field widths.
    localparam int CELL_W = 5;
    localparam int FIX_W  = 20;
    localparam int SIZE_W = 16;
    localparam int FRAC_W = 4;

    // Edge sum is one bit wider than a coordinate; whole pixels drop the fraction.
    localparam int SUM_W      = FIX_W + 1;
    localparam int PX_W       = SUM_W - FRAC_W;
    localparam int PX_MAG_W   = PX_W - 1;
    localparam int QUOT_W     = PX_MAG_W;
    localparam int FRAC_ROUND = (1 << FRAC_W) - 1;

    // Edge slots.
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_TOP    = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_BOTTOM = 3;
    localparam int EDGE_COUNT  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_READ,
        ST_TEST
    } tmac_state_t;

    typedef struct packed {
        logic load;
        logic write_cell;
        logic divide;
        logic scan_init;
        logic rd_en;
        logic advance;
        logic res_load;
        logic res_hit;
    } tmac_cmd_t;

    typedef struct packed {
        logic out_of_map;
        logic is_wall;
        logic scan_last;
    } tmac_sts_t;

    // Fixed point to whole pixels, truncating toward zero.
    function automatic logic signed [PX_W-1:0] fix_to_px(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v + (v[SUM_W-1] ? SUM_W'(FRAC_ROUND) : SUM_W'(0));
        return t[SUM_W-1:FRAC_W];
    endfunction

endpackage

### hw/rtl/tmac_ctrl.sv
// Controller state machine that sequences writes, queries and the tile scan.
module tmac_ctrl
    import tmac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      command,
    output logic      out_valid,
    input  logic      out_stall,
    output tmac_cmd_t cmd,
    input  tmac_sts_t sts
);

    tmac_state_t state_reg;
    tmac_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accept;
    logic        res_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    // The result register can take a new result when empty or being drained.
    assign res_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        cmd.write_cell = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.divide = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.out_of_map)
                begin
                    if (res_free)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_hit  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (sts.is_wall || sts.scan_last)
                begin
                    if (res_free)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_hit  = sts.is_wall;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

### hw/rtl/tmac_dp.sv
// Datapath: wall id registers, tile memory, edge to tile conversion and scan counters.
module tmac_dp
    import tmac_pkg::*;
#(
    parameter int MAP_WIDTH   = 32,
    parameter int MAP_HEIGHT  = 32,
    parameter int TILE_PIXELS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [TILE_ID_W-1:0]        cfg_data,
    input  logic [CELL_W-1:0]           cell_column,
    input  logic [CELL_W-1:0]           cell_row,
    input  logic [TILE_ID_W-1:0]        cell_tile,
    input  logic signed [FIX_W-1:0]     left_edge,
    input  logic signed [FIX_W-1:0]     top_edge,
    input  logic [SIZE_W-1:0]           area_wide,
    input  logic [SIZE_W-1:0]           area_tall,
    input  tmac_cmd_t                   cmd,
    output tmac_sts_t                   sts,
    output logic                        wall_hit
);

    localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W    = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
    localparam int COL_W     = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
    localparam int ROW_W     = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
    localparam int LIM_W     = 9;

    // Exact division of a PX_MAG_W-bit value by TILE_PIXELS: multiply by a
    // rounded-up reciprocal and shift.
    localparam int TILE_SH = $clog2(TILE_PIXELS);
    localparam int DIV_SH  = PX_MAG_W + TILE_SH;
    localparam int MUL_W   = PX_MAG_W + 1;
    localparam int PROD_W  = PX_MAG_W + MUL_W;
    localparam longint DIV_MUL =
        ((longint'(1) << DIV_SH) + longint'(TILE_PIXELS) - 1) / longint'(TILE_PIXELS);
    localparam logic [MUL_W-1:0] MUL_K = MUL_W'(DIV_MUL);
    localparam logic signed [PX_W-1:0] NEG_TILE = PX_W'(-TILE_PIXELS);

    logic [TILE_ID_W-1:0] wall_first_reg;
    logic [TILE_ID_W-1:0] wall_second_reg;
    logic [TILE_ID_W-1:0] wall_third_reg;
    logic [TILE_ID_W-1:0] wall_fourth_reg;

    logic [TILE_ID_W-1:0] tile_mem [MAP_CELLS];
    logic [TILE_ID_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_in_map;

    logic signed [SUM_W-1:0] sum_val [EDGE_COUNT];
    logic signed [PX_W-1:0]  px_next [EDGE_COUNT];
    logic signed [PX_W-1:0]  px_reg  [EDGE_COUNT];
    logic [QUOT_W-1:0]       q_next  [EDGE_COUNT];
    logic [QUOT_W-1:0]       q_reg   [EDGE_COUNT];
    logic [PROD_W-1:0]       prod    [EDGE_COUNT];
    logic [PROD_W-1:0]       prod_sh [EDGE_COUNT];
    logic                    neg_left_reg;
    logic                    neg_top_reg;

    logic [COL_W-1:0] tx_reg;
    logic [ROW_W-1:0] ty_reg;
    logic [COL_W-1:0] left_col;
    logic [COL_W-1:0] right_col;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic             wall_hit_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_first_reg  <= WALL_FIRST_RST;
            wall_second_reg <= WALL_SECOND_RST;
            wall_third_reg  <= WALL_THIRD_RST;
            wall_fourth_reg <= WALL_FOURTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WALL_FIRST:  wall_first_reg  <= cfg_data;
                REG_WALL_SECOND: wall_second_reg <= cfg_data;
                REG_WALL_THIRD:  wall_third_reg  <= cfg_data;
                REG_WALL_FOURTH: wall_fourth_reg <= cfg_data;
                default:         wall_first_reg  <= wall_first_reg;
            endcase
        end
    end

    // Tile memory: one write port for cell loads, one registered read port for the scan.
    assign wr_in_map = (LIM_W'(cell_column) < LIM_W'(MAP_WIDTH)) &&
                       (LIM_W'(cell_row) < LIM_W'(MAP_HEIGHT));
    assign wr_addr   = ADDR_W'(32'(cell_row) * 32'(MAP_WIDTH) + 32'(cell_column));
    assign rd_addr   = ADDR_W'(32'(ty_reg) * 32'(MAP_WIDTH) + 32'(tx_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.write_cell && wr_in_map)
        begin
            tile_mem[wr_addr] <= cell_tile;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= tile_mem[rd_addr];
        end
    end

    // Edges in whole pixels, captured when a query is taken.
    always_comb
    begin
        sum_val[EDGE_LEFT]   = SUM_W'(left_edge);
        sum_val[EDGE_TOP]    = SUM_W'(top_edge);
        sum_val[EDGE_RIGHT]  = SUM_W'(left_edge) + $signed(SUM_W'(area_wide));
        sum_val[EDGE_BOTTOM] = SUM_W'(top_edge) + $signed(SUM_W'(area_tall));
        for (int e = 0; e < EDGE_COUNT; e++)
        begin
            px_next[e] = fix_to_px(sum_val[e]);
        end
    end

    // Pixel to tile index. A negative pixel gives tile zero; only the left and
    // top edges need to know whether the tile index itself is negative.
    always_comb
    begin
        for (int e = 0; e < EDGE_COUNT; e++)
        begin
            prod[e]    = PROD_W'(px_reg[e][PX_MAG_W-1:0]) * PROD_W'(MUL_K);
            prod_sh[e] = prod[e] >> DIV_SH;
            q_next[e]  = px_reg[e][PX_W-1] ? '0 : prod_sh[e][QUOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= px_next;
        end
        if (cmd.divide)
        begin
            q_reg        <= q_next;
            neg_left_reg <= (px_reg[EDGE_LEFT] <= NEG_TILE);
            neg_top_reg  <= (px_reg[EDGE_TOP] <= NEG_TILE);
        end
    end

    assign sts.out_of_map = neg_left_reg || neg_top_reg ||
                            (q_reg[EDGE_RIGHT] >= QUOT_W'(MAP_WIDTH)) ||
                            (q_reg[EDGE_BOTTOM] >= QUOT_W'(MAP_HEIGHT));

    // Scan counters walk the covered tiles row by row.
    assign left_col   = q_reg[EDGE_LEFT][COL_W-1:0];
    assign right_col  = q_reg[EDGE_RIGHT][COL_W-1:0];
    assign top_row    = q_reg[EDGE_TOP][ROW_W-1:0];
    assign bottom_row = q_reg[EDGE_BOTTOM][ROW_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            tx_reg <= left_col;
            ty_reg <= top_row;
        end
        else if (cmd.advance)
        begin
            if (tx_reg == right_col)
            begin
                tx_reg <= left_col;
                ty_reg <= ty_reg + 1'b1;
            end
            else
            begin
                tx_reg <= tx_reg + 1'b1;
            end
        end
    end

    assign sts.scan_last = (tx_reg == right_col) && (ty_reg == bottom_row);
    assign sts.is_wall   = (rd_data_reg == wall_first_reg) ||
                           (rd_data_reg == wall_second_reg) ||
                           (rd_data_reg == wall_third_reg) ||
                           (rd_data_reg == wall_fourth_reg);

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            wall_hit_reg <= cmd.res_hit;
        end
    end

    assign wall_hit = wall_hit_reg;

endmodule

### hw/rtl/tile_map_area_collision.sv
// Top level of the tile map area collision block: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall | command, cell_*, left/top_edge, area_*
//  out     | output    | out_valid/out_stall | wall_hit
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A write item leaves the block idle, so it is ready again in the next cycle.
// A query holds in_stall high through ST_DIVIDE (reciprocal multiply), ST_CHECK (map range
// check), then ST_READ and ST_TEST per covered tile, set by the single registered read port
// of the tile memory; its result loads in ST_CHECK if off the map, else in the last ST_TEST.
// Reset is asynchronous and active low; it resets the controller and the wall ids only.
// A stalled result holds its register; items are still taken, a finished query waits.
module tile_map_area_collision
    import tmac_pkg::*;
#(
    parameter int MAP_WIDTH   = 32,
    parameter int MAP_HEIGHT  = 32,
    parameter int TILE_PIXELS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [TILE_ID_W-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    command,
    input  logic [CELL_W-1:0]       cell_column,
    input  logic [CELL_W-1:0]       cell_row,
    input  logic [TILE_ID_W-1:0]    cell_tile,
    input  logic signed [FIX_W-1:0] left_edge,
    input  logic signed [FIX_W-1:0] top_edge,
    input  logic [SIZE_W-1:0]       area_wide,
    input  logic [SIZE_W-1:0]       area_tall,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    wall_hit
);

    tmac_cmd_t cmd;
    tmac_sts_t sts;

    // The controller decides when items are taken and when the result loads.
    tmac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the map, the wall ids and the query arithmetic.
    tmac_dp #(
        .MAP_WIDTH   (MAP_WIDTH),
        .MAP_HEIGHT  (MAP_HEIGHT),
        .TILE_PIXELS (TILE_PIXELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .cell_tile   (cell_tile),
        .left_edge   (left_edge),
        .top_edge    (top_edge),
        .area_wide   (area_wide),
        .area_tall   (area_tall),
        .cmd         (cmd),
        .sts         (sts),
        .wall_hit    (wall_hit)
    );

endmodule

### hw/rtl/tmac_checker.sv
// Port level checks of the tile map collision block and their bind.
`include "assert_macros.svh"

module tmac_checker
    import tmac_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic command,
    input logic out_valid,
    input logic out_stall,
    input logic wall_hit
);

    // A held result keeps its value.
    `TMAC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(wall_hit))
    // A taken query occupies the block in the next cycle.
    `TMAC_ASSERT(a_query_busy, clk, rst_n, in_valid && !in_stall && command == CMD_QUERY |=> in_stall)
    // A taken write leaves the block ready for the next item.
    `TMAC_ASSERT(a_write_ready, clk, rst_n, in_valid && !in_stall && command == CMD_WRITE |=> !in_stall)
    // A new result only comes from a query that was in progress.
    `TMAC_ASSERT(a_result_source, clk, rst_n, $rose(out_valid) |-> $past(in_stall))
    // Reset leaves the block idle with no result.
    `TMAC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid && !in_stall)

endmodule

bind tile_map_area_collision tmac_checker u_checker (.*);

### verif/tb.sv
// Self-checking testbench of the tile map area collision block, with its own model of the map.
module tb;
    import tmac_pkg::*;

    // Geometry of the instance under test. One tile spans TILE_PX whole pixels, and
    // one whole pixel is 16 steps of the fixed point coordinates.
    localparam int MAP_W     = 32;
    localparam int MAP_H     = 32;
    localparam int TILE_PX   = 32;
    localparam int TILE_FIX  = TILE_PX << FRAC_W;
    localparam int MAP_W_FIX = MAP_W * TILE_FIX;
    localparam int MAP_H_FIX = MAP_H * TILE_FIX;

    // A full map scan reads every tile in turn, so the quiet limit of the watchdog
    // sits well above the length of such a scan and above the long output hold-off.
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 12;
    localparam int PHASE_ITEMS  = 25;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [TILE_ID_W-1:0]    cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    command;
    logic [CELL_W-1:0]       cell_column;
    logic [CELL_W-1:0]       cell_row;
    logic [TILE_ID_W-1:0]    cell_tile;
    logic signed [FIX_W-1:0] left_edge;
    logic signed [FIX_W-1:0] top_edge;
    logic [SIZE_W-1:0]       area_wide;
    logic [SIZE_W-1:0]       area_tall;
    logic                    out_valid;
    logic                    out_stall;
    logic                    wall_hit;

    // Our own copy of the map and of the wall id registers, updated as items and
    // register writes are taken by the block.
    logic [TILE_ID_W-1:0] map_tiles [MAP_H][MAP_W];
    logic [TILE_ID_W-1:0] wall_ids [4];

    // One expected wall_hit per accepted query, oldest first.
    logic expected_hits [$];
    int   mismatch_count;

    // Sender pacing: bursts of items with random gaps, or a steady stream.
    bit   feed_open;
    bit   feed_bursty;
    int   burst_left;

    // Receiver pacing: 0 never stalls, 1 stalls at random, 2 stalls in runs.
    int   sink_mode;
    bit   hold_request;

    tile_map_area_collision #(
        .MAP_WIDTH   (MAP_W),
        .MAP_HEIGHT  (MAP_H),
        .TILE_PIXELS (TILE_PX)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .cell_tile   (cell_tile),
        .left_edge   (left_edge),
        .top_edge    (top_edge),
        .area_wide   (area_wide),
        .area_tall   (area_tall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .wall_hit    (wall_hit)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Whole pixels and then tiles, both divisions truncating toward zero. A tile
    // index only goes negative once the edge reaches minus one full tile of pixels.
    function automatic int tile_of(int fixed_pos);
        return (fixed_pos / (1 << FRAC_W)) / TILE_PX;
    endfunction

    function automatic bit is_wall_id(logic [TILE_ID_W-1:0] id);
        return id == wall_ids[0] || id == wall_ids[1] || id == wall_ids[2] || id == wall_ids[3];
    endfunction

    // Expected answer of one query against the current map and wall ids.
    function automatic logic predict_wall_hit(logic signed [FIX_W-1:0] x,
                                              logic signed [FIX_W-1:0] y,
                                              logic [SIZE_W-1:0] w,
                                              logic [SIZE_W-1:0] h);
        int lft;
        int rgt;
        int tp;
        int btm;
        lft = tile_of(int'(x));
        rgt = tile_of(int'(x) + int'(w));
        tp  = tile_of(int'(y));
        btm = tile_of(int'(y) + int'(h));
        if (lft < 0 || tp < 0 || rgt >= MAP_W || btm >= MAP_H)
            return 1'b1;
        for (int ty = tp; ty <= btm; ty++)
            for (int tx = lft; tx <= rgt; tx++)
                if (is_wall_id(map_tiles[ty][tx]))
                    return 1'b1;
        return 1'b0;
    endfunction

    // Offers one item and returns in the step of the edge that took it. The valid
    // stays high when the next item follows at once, so the caller must either
    // send again in the same step or close the feed.
    task automatic send_item(input logic cmd, input logic [CELL_W-1:0] col,
                             input logic [CELL_W-1:0] row, input logic [TILE_ID_W-1:0] tile,
                             input logic signed [FIX_W-1:0] x, input logic signed [FIX_W-1:0] y,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        int gap;
        in_valid    <= 1'b1;
        command     <= cmd;
        cell_column <= col;
        cell_row    <= row;
        cell_tile   <= tile;
        left_edge   <= x;
        top_edge    <= y;
        area_wide   <= w;
        area_tall   <= h;
        feed_open = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);

        // The item is taken at this edge; fold it into the model right away.
        if (cmd == CMD_WRITE)
            map_tiles[row][col] = tile;
        else
            expected_hits.push_back(predict_wall_hit(x, y, w, h));

        gap = 0;
        if (feed_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 6);
            end
            else
                burst_left--;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            feed_open = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Writes carry random rectangle fields and queries random cell fields, since
    // the block has to ignore them.
    task automatic write_cell(input int col, input int row, input int tile);
        send_item(CMD_WRITE, CELL_W'(col), CELL_W'(row), TILE_ID_W'(tile),
                  FIX_W'($urandom()), FIX_W'($urandom()), SIZE_W'($urandom()),
                  SIZE_W'($urandom()));
    endtask

    task automatic query_area(input int x, input int y, input int w, input int h);
        send_item(CMD_QUERY, CELL_W'($urandom()), CELL_W'($urandom()),
                  TILE_ID_W'($urandom()), FIX_W'(x), FIX_W'(y), SIZE_W'(w), SIZE_W'(h));
    endtask

    // Stops offering, waits for every outstanding answer, then lets the block
    // finish any write that is still in flight.
    task automatic wait_drained();
        if (feed_open)
        begin
            in_valid <= 1'b0;
            feed_open = 1'b0;
        end
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic set_walls(input int first, input int second, input int third,
                             input int fourth);
        logic [CFG_IDX_W-1:0] idx [4];
        int vals [4];
        idx  = '{REG_WALL_FIRST, REG_WALL_SECOND, REG_WALL_THIRD, REG_WALL_FOURTH};
        vals = '{first, second, third, fourth};
        wait_drained();
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= TILE_ID_W'(vals[i]);
            @(posedge clk);
            wall_ids[i] = TILE_ID_W'(vals[i]);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Every cell gets written before any query can scan it, so no query ever
    // reads a cell the block has not been given. Walls are kept rare.
    task automatic test_map_load();
        feed_bursty = 1'b1;
        sink_mode = 1;
        for (int row = 0; row < MAP_H; row++)
            for (int col = 0; col < MAP_W; col++)
                write_cell(col, row, ($urandom_range(0, 31) == 0) ?
                           $urandom_range(1, 4) : $urandom_range(5, 255));
    endtask

    // Edges of the map, the negative truncation boundary, field extremes and a
    // single wall tile turned on and off.
    task automatic test_edges_directed();
        write_cell(0, 0, 8'h5A);
        write_cell(MAP_W - 1, MAP_H - 1, 8'hA5);
        query_area(0, 0, 0, 0);
        // Just above minus one tile of pixels the index truncates to zero.
        query_area(-(TILE_FIX - 1), -1, 0, 0);
        query_area(-TILE_FIX, 0, 0, 0);
        query_area(-(TILE_FIX + 15), 0, 0, 0);
        query_area(0, -TILE_FIX, 0, 0);
        // The last tile on both axes, then one pixel past it.
        query_area(MAP_W_FIX - TILE_FIX, MAP_H_FIX - TILE_FIX, TILE_FIX - 1, TILE_FIX - 1);
        query_area(MAP_W_FIX - TILE_FIX, MAP_H_FIX - TILE_FIX, TILE_FIX, 0);
        query_area(MAP_W_FIX - TILE_FIX, MAP_H_FIX - TILE_FIX, 0, TILE_FIX);
        query_area(0, 0, TILE_FIX, 0);
        // The whole map in one rectangle.
        query_area(0, 0, MAP_W_FIX - 1, MAP_H_FIX - 1);
        // Extremes of the coordinate and size fields.
        query_area(-524288, 524287, 65535, 65535);
        query_area(524287, -524288, 0, 0);
        query_area(-1, -1, 65535, 0);
        query_area(0, 0, 0, 65535);
        // One tile switched to a wall id and back.
        write_cell(5, 7, 3);
        query_area(5 * TILE_FIX + 100, 7 * TILE_FIX, 0, 0);
        write_cell(5, 7, 8'hFF);
        query_area(5 * TILE_FIX + 100, 7 * TILE_FIX, 0, 0);
    endtask

    // Wall ids at both ends of their range, including id zero.
    task automatic test_wall_extremes();
        set_walls(8'h00, 8'hFF, 8'h00, 8'hFF);
        write_cell(2, 2, 8'h00);
        write_cell(3, 2, 8'hFF);
        write_cell(4, 2, 8'h01);
        for (int col = 2; col <= 4; col++)
            query_area(col * TILE_FIX + 7, 2 * TILE_FIX + 31, 15, 15);
        query_area(2 * TILE_FIX, 2 * TILE_FIX, 3 * TILE_FIX - 1, 0);
        set_walls(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        query_area(3 * TILE_FIX, 2 * TILE_FIX, 0, 0);
        query_area(2 * TILE_FIX, 2 * TILE_FIX, 0, 0);
    endtask

    // One random item. Most are sprite-sized queries inside or around the map,
    // some sit on the map border, a few use the full field range, and a fifth
    // rewrite cells, often with a current wall id.
    task automatic random_item();
        int roll;
        int x;
        int y;
        int w;
        int h;
        roll = $urandom_range(0, 99);
        if (roll < 20)
        begin
            write_cell($urandom_range(0, MAP_W - 1), $urandom_range(0, MAP_H - 1),
                       ($urandom_range(0, 3) == 0) ? int'(wall_ids[$urandom_range(0, 3)]) :
                       $urandom_range(0, 255));
        end
        else if (roll < 85)
        begin
            x = $urandom_range(0, MAP_W_FIX + 900) - 640;
            y = $urandom_range(0, MAP_H_FIX + 900) - 640;
            w = $urandom_range(0, 1200);
            h = $urandom_range(0, 1200);
            // Now and then a rectangle spanning most of the map.
            if ($urandom_range(0, 99) == 0)
            begin
                x = $urandom_range(0, 255);
                y = $urandom_range(0, 255);
                w = $urandom_range(MAP_W_FIX / 2, MAP_W_FIX - 256);
                h = $urandom_range(MAP_H_FIX / 2, MAP_H_FIX - 256);
            end
            query_area(x, y, w, h);
        end
        else if (roll < 95)
        begin
            x = $urandom_range(0, 1) ? $urandom_range(0, 40) - (TILE_FIX + 20) :
                MAP_W_FIX - TILE_FIX + $urandom_range(0, 600);
            y = $urandom_range(0, 1) ? $urandom_range(0, 40) - (TILE_FIX + 20) :
                MAP_H_FIX - TILE_FIX + $urandom_range(0, 600);
            query_area(x, y, $urandom_range(0, 600), $urandom_range(0, 600));
        end
        else
            query_area($urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // Several register settings, with the pacing on both sides changing between
    // them; one phase runs with no idling at all.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_walls(WALL_FIRST_RST, WALL_SECOND_RST, WALL_THIRD_RST, WALL_FOURTH_RST);
                1: set_walls($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255));
                2: set_walls(8'h00, 8'h01, 8'hFE, 8'hFF);
                default: set_walls($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255));
            endcase
            feed_bursty = (phase != 2);
            sink_mode = (phase == 2) ? 0 : 1 + (phase % 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end
    endtask

    // The receiver holds off for a long stretch while small queries keep coming,
    // so the result register fills and the block has to stall its input.
    task automatic test_backpressure();
        wait_drained();
        feed_bursty = 1'b0;
        sink_mode = 0;
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++)
            query_area($urandom_range(0, MAP_W_FIX - 600), $urandom_range(0, MAP_H_FIX - 600),
                       $urandom_range(0, 500), $urandom_range(0, 500));
        wait_drained();
        feed_bursty = 1'b1;
        sink_mode = 2;
        for (int n = 0; n < 40; n++)
            random_item();
    endtask

    // Receiver side: a long hold-off on request, otherwise the current pattern.
    initial
    begin
        int hold_left;
        int run_left;
        bit run_level;
        hold_left = 0;
        run_left = 0;
        run_level = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (sink_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else if (sink_mode == 2)
            begin
                if (run_left == 0)
                begin
                    run_level = ~run_level;
                    run_left = run_level ? $urandom_range(1, 12) : $urandom_range(1, 20);
                end
                run_left--;
                out_stall <= run_level;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker: every answer taken from the block must match the oldest
    // expectation, and no answer may come when none is expected.
    initial
    begin
        logic want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_hits.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got wall_hit=%b",
                             $time, wall_hit);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (wall_hit !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: wall_hit mismatch, expected %b, got %b",
                                 $time, want, wall_hit);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side means a hang.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        feed_open = 1'b0;
        feed_bursty = 1'b1;
        burst_left = 0;
        sink_mode = 0;
        hold_request = 1'b0;
        wall_ids = '{WALL_FIRST_RST, WALL_SECOND_RST, WALL_THIRD_RST, WALL_FOURTH_RST};
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_WALL_FIRST;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        command     <= CMD_WRITE;
        cell_column <= '0;
        cell_row    <= '0;
        cell_tile   <= '0;
        left_edge   <= '0;
        top_edge    <= '0;
        area_wide   <= '0;
        area_tall   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_map_load();
        test_edges_directed();
        test_wall_extremes();
        test_random_traffic();
        test_backpressure();
        wait_drained();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
